### hdl/ws2812_pkg.sv
// ----------------------------------------------------------------------------
// ws2812_pkg
// Shared types and constants for the serial RGB LED strip driver.
// ----------------------------------------------------------------------------
package ws2812_pkg;

	localparam int MAX_LEDS_DEF = 72;

	// request kinds carried on the input tuser
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_ZERO_HIGH = 3'd0;
	localparam logic [2:0] REG_ZERO_LOW  = 3'd1;
	localparam logic [2:0] REG_ONE_HIGH  = 3'd2;
	localparam logic [2:0] REG_ONE_LOW   = 3'd3;
	localparam logic [2:0] REG_GAP       = 3'd4;
	localparam logic [2:0] REG_LED_COUNT = 3'd5;

	localparam logic [7:0]  ZERO_HIGH_RST = 8'd22;
	localparam logic [7:0]  ZERO_LOW_RST  = 8'd66;
	localparam logic [7:0]  ONE_HIGH_RST  = 8'd44;
	localparam logic [7:0]  ONE_LOW_RST   = 8'd44;
	localparam logic [15:0] GAP_RST       = 16'd5760;
	localparam logic [6:0]  LED_COUNT_RST = 7'd72;

	// index of a pixel's last bit; pixels are sent green, red, blue, MSB first
	localparam logic [4:0] LAST_BIT = 5'd23;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_HIGH = 4'b0010,
		PH_LOW  = 4'b0100,
		PH_GAP  = 4'b1000
	} phase_t;

endpackage

### hdl/ws2812_led_strip_driver.sv
// ----------------------------------------------------------------------------
// ws2812_led_strip_driver
// Single-wire RGB LED strip driver with pixel store, bit timer and reset gap.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  s_*      | in  | s_tvalid / s_tready     | s_tuser mode, s_tdata pixel write
//  m_*      | out | m_tvalid / m_tready     | m_tdata line/busy, m_tlast frame done
//  apb      | in  | psel & penable, pready  | timing registers, led count
//
//  One request per clock while s_tready is high; each request gives one result, registered in the cycle after.
//  s_tready drops only while the result register is full and m_tready is low.
//  The pixel store reads as zero after reset through per-entry valid flops;
//  no clearing pass is needed. The next pixel is prefetched from the store
//  while the current one is shifting out, pixel 0 is held in a register.
// ----------------------------------------------------------------------------
module ws2812_led_strip_driver #(
	parameter int MAX_LEDS = ws2812_pkg::MAX_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // led_index[6:0], red[14:7], green[22:15], blue[30:23]
	input  logic [1:0]  s_tuser,   // mode[1:0]

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // line_level[0], busy_res[1]
	output logic        m_tlast,   // frame_done

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int PW  = $clog2(MAX_LEDS + 1);
	localparam int XW  = (AW > 7) ? AW : 7;
	localparam int CXW = (PW > 7) ? PW : 7;

	// ---------------- configuration ----------------
	logic [7:0]  zero_high_q, zero_low_q, one_high_q, one_low_q;
	logic [15:0] gap_q;
	logic [6:0]  led_count_q;
	logic        cfg_we;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= ws2812_pkg::ZERO_HIGH_RST;
			zero_low_q  <= ws2812_pkg::ZERO_LOW_RST;
			one_high_q  <= ws2812_pkg::ONE_HIGH_RST;
			one_low_q   <= ws2812_pkg::ONE_LOW_RST;
			gap_q       <= ws2812_pkg::GAP_RST;
			led_count_q <= ws2812_pkg::LED_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ws2812_pkg::REG_ZERO_HIGH: zero_high_q <= pwdata[7:0];
				ws2812_pkg::REG_ZERO_LOW:  zero_low_q  <= pwdata[7:0];
				ws2812_pkg::REG_ONE_HIGH:  one_high_q  <= pwdata[7:0];
				ws2812_pkg::REG_ONE_LOW:   one_low_q   <= pwdata[7:0];
				ws2812_pkg::REG_GAP:       gap_q       <= pwdata[15:0];
				ws2812_pkg::REG_LED_COUNT: led_count_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			ws2812_pkg::REG_ZERO_HIGH: prdata = {24'd0, zero_high_q};
			ws2812_pkg::REG_ZERO_LOW:  prdata = {24'd0, zero_low_q};
			ws2812_pkg::REG_ONE_HIGH:  prdata = {24'd0, one_high_q};
			ws2812_pkg::REG_ONE_LOW:   prdata = {24'd0, one_low_q};
			ws2812_pkg::REG_GAP:       prdata = {16'd0, gap_q};
			ws2812_pkg::REG_LED_COUNT: prdata = {25'd0, led_count_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// led count clamped to 1..MAX_LEDS
	logic [CXW-1:0] lc_x, act_cnt;
	always_comb begin
		lc_x = CXW'(led_count_q);
		if (led_count_q == 7'd0)
			act_cnt = CXW'(1);
		else if (lc_x > CXW'(MAX_LEDS))
			act_cnt = CXW'(MAX_LEDS);
		else
			act_cnt = lc_x;
	end

	// ---------------- request decode ----------------
	logic        acc;
	logic [1:0]  mode;
	logic [6:0]  led_index;
	logic [7:0]  red, green, blue;
	logic [XW-1:0] idx_x;

	assign s_tready  = !m_tvalid || m_tready;
	assign acc       = s_tvalid && s_tready;
	assign mode      = s_tuser;
	assign led_index = s_tdata[6:0];
	assign red       = s_tdata[14:7];
	assign green     = s_tdata[22:15];
	assign blue      = s_tdata[30:23];
	assign idx_x     = XW'(led_index);

	// ---------------- sequencer state ----------------
	ws2812_pkg::phase_t phase_q, phase_d;
	logic [PW-1:0]  pos_q, pos_d;
	logic [4:0]     bit_q, bit_d;
	logic [15:0]    tick_q, tick_d;
	logic [23:0]    shift_q, shift_d;
	logic           line_q, line_d;
	logic           done_d;
	logic           idle;

	assign idle = (phase_q == ws2812_pkg::PH_IDLE);

	// ---------------- pixel store ----------------
	logic [23:0]   mem [MAX_LEDS];
	logic          vld_q [MAX_LEDS];
	logic [23:0]   pix0_q;
	logic          mem_we;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [PW-1:0] rd_pos;
	logic          rd_in_range;
	logic [23:0]   rd_data_q;
	logic          rd_vld_q;
	logic [23:0]   next_pix;

	assign mem_we      = acc && (mode == ws2812_pkg::MODE_WRITE) && idle &&
	                     (idx_x < XW'(MAX_LEDS));
	assign wr_addr     = idx_x[AW-1:0];
	assign rd_pos      = pos_q + PW'(1);
	assign rd_addr     = rd_pos[AW-1:0];
	assign rd_in_range = (rd_pos < PW'(MAX_LEDS));
	assign next_pix    = rd_vld_q ? rd_data_q : 24'd0;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= {green, red, blue};
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEDS; i++)
				vld_q[i] <= 1'b0;
			pix0_q   <= 24'd0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[wr_addr] <= 1'b1;
				if (wr_addr == AW'(0))
					pix0_q <= {green, red, blue};
			end
			rd_vld_q <= rd_in_range && vld_q[rd_addr];
		end
	end

	// ---------------- next state ----------------
	logic [16:0] tick_inc;
	logic        bit_one;
	logic [7:0]  hi_thr, lo_thr;
	logic [CXW-1:0] pos_inc;

	assign tick_inc = {1'b0, tick_q} + 17'd1;
	assign bit_one  = shift_q[23];
	assign hi_thr   = bit_one ? one_high_q : zero_high_q;
	assign lo_thr   = bit_one ? one_low_q : zero_low_q;
	assign pos_inc  = CXW'(pos_q) + CXW'(1);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		line_d  = line_q;
		done_d  = 1'b0;
		if (acc) begin
			unique case (mode)
				ws2812_pkg::MODE_START: begin
					if (idle) begin
						phase_d = ws2812_pkg::PH_HIGH;
						pos_d   = PW'(0);
						bit_d   = 5'd0;
						tick_d  = 16'd0;
						shift_d = pix0_q;
					end
				end
				ws2812_pkg::MODE_TICK: begin
					unique case (phase_q)
						ws2812_pkg::PH_HIGH: begin
							line_d = 1'b1;
							if (tick_inc >= {9'd0, hi_thr}) begin
								phase_d = ws2812_pkg::PH_LOW;
								tick_d  = 16'd0;
							end else begin
								tick_d = tick_inc[15:0];
							end
						end
						ws2812_pkg::PH_LOW: begin
							line_d = 1'b0;
							if (tick_inc >= {9'd0, lo_thr}) begin
								tick_d  = 16'd0;
								bit_d   = bit_q + 5'd1;
								shift_d = {shift_q[22:0], 1'b0};
								phase_d = ws2812_pkg::PH_HIGH;
								if (bit_q == ws2812_pkg::LAST_BIT) begin
									pos_d = pos_inc[PW-1:0];
									if (pos_inc >= act_cnt) begin
										phase_d = ws2812_pkg::PH_GAP;
									end else begin
										shift_d = next_pix;
										bit_d   = 5'd0;
									end
								end
							end else begin
								tick_d = tick_inc[15:0];
							end
						end
						ws2812_pkg::PH_GAP: begin
							line_d = 1'b0;
							if (tick_inc >= {1'b0, gap_q}) begin
								tick_d  = 16'd0;
								phase_d = ws2812_pkg::PH_IDLE;
								done_d  = 1'b1;
							end else begin
								tick_d = tick_inc[15:0];
							end
						end
						default: line_d = 1'b0;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ws2812_pkg::PH_IDLE;
			pos_q   <= '0;
			bit_q   <= 5'd0;
			tick_q  <= 16'd0;
			shift_q <= 24'd0;
			line_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			line_q  <= line_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			m_tdata <= {6'd0, (phase_d != ws2812_pkg::PH_IDLE), line_d};
			m_tlast <= done_d;
		end
	end

	// ---------------- assertions ----------------
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[1])
		else $error("frame done reported while still busy");

	a_line_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("line driven high while idle");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> phase_q == ws2812_pkg::PH_IDLE)
		else $error("pixel store written during a refresh");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ws2812_pkg::PH_HIGH || phase_q == ws2812_pkg::PH_LOW)
		|-> pos_q < PW'(MAX_LEDS))
		else $error("pixel position beyond store while sending");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && mode == ws2812_pkg::MODE_START && idle
		|=> phase_q == ws2812_pkg::PH_HIGH && tick_q == 16'd0 && bit_q == 5'd0)
		else $error("start request did not begin a frame");

endmodule

### test/tb_ws2812_led_strip_driver.sv
// ----------------------------------------------------------------------------
// tb_ws2812_led_strip_driver
// Self-checking bench for the LED strip driver. Pixel writes, refresh starts
// and timer ticks go in on the request stream; each result is compared with
// the line level, busy and frame-done that a cycle-free model of the strip
// predicts. Covers register reset values, reset bit timing with a mid-frame
// register change, zero bit timings, a zero LED count, requests ignored while
// busy, long output stalls and randomized traffic with random idling on both
// sides.
// ----------------------------------------------------------------------------
module tb_ws2812_led_strip_driver;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned RANDOM_PHASE_ITEMS = 30;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} strip_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // led_index[6:0], red[14:7], green[22:15], blue[30:23]
	logic [1:0]  s_tuser;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // line_level[0], busy_res[1]
	logic        m_tlast;   // frame_done
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// strip model state
	logic [7:0]   cfg_zero_high;
	logic [7:0]   cfg_zero_low;
	logic [7:0]   cfg_one_high;
	logic [7:0]   cfg_one_low;
	logic [15:0]  cfg_gap;
	logic [6:0]   cfg_led_count;
	logic [23:0]  pixel_mem [0:ws2812_pkg::MAX_LEDS_DEF-1];
	logic         strip_busy;
	int unsigned  pixel_pos;
	int unsigned  bit_pos;
	ws2812_pkg::phase_t wave_phase;
	int unsigned  tick_count;
	logic [23:0]  shift_word;
	logic         line_q;

	strip_result_t strip_expected[$];
	int            mismatch_count = 0;
	int            hold_cycles = 0;
	bit            idle_on = 1'b1;

	ws2812_led_strip_driver i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void reset_strip_model();
		cfg_zero_high = ws2812_pkg::ZERO_HIGH_RST;
		cfg_zero_low  = ws2812_pkg::ZERO_LOW_RST;
		cfg_one_high  = ws2812_pkg::ONE_HIGH_RST;
		cfg_one_low   = ws2812_pkg::ONE_LOW_RST;
		cfg_gap       = ws2812_pkg::GAP_RST;
		cfg_led_count = ws2812_pkg::LED_COUNT_RST;
		for (int i = 0; i < ws2812_pkg::MAX_LEDS_DEF; i++)
			pixel_mem[i] = '0;
		strip_busy = 1'b0;
		pixel_pos  = 0;
		bit_pos    = 0;
		wave_phase = ws2812_pkg::PH_IDLE;
		tick_count = 0;
		shift_word = '0;
		line_q     = 1'b0;
	endfunction

	// zero counts as one pixel, anything past the store as a full store
	function automatic int unsigned strip_led_total();
		if (cfg_led_count == 0)
			return 1;
		if (cfg_led_count > ws2812_pkg::MAX_LEDS_DEF)
			return ws2812_pkg::MAX_LEDS_DEF;
		return {25'd0, cfg_led_count};
	endfunction

	function automatic strip_result_t advance_strip(input logic [1:0] mode,
			input logic [6:0] idx, input logic [7:0] red, green, blue);
		strip_result_t res;
		logic          bit_is_one;
		logic          done;
		done = 1'b0;
		case (mode)
			ws2812_pkg::MODE_WRITE: begin
				if (!strip_busy && idx < ws2812_pkg::MAX_LEDS_DEF)
					pixel_mem[idx] = {green, red, blue};
			end
			ws2812_pkg::MODE_START: begin
				if (!strip_busy) begin
					strip_busy = 1'b1;
					pixel_pos  = 0;
					shift_word = pixel_mem[0];
					bit_pos    = 0;
					tick_count = 0;
					wave_phase = ws2812_pkg::PH_HIGH;
				end
			end
			ws2812_pkg::MODE_TICK: begin
				bit_is_one = shift_word[23];
				case (wave_phase)
					ws2812_pkg::PH_HIGH: begin
						line_q = 1'b1;
						tick_count++;
						if (tick_count >= (bit_is_one ? cfg_one_high : cfg_zero_high)) begin
							wave_phase = ws2812_pkg::PH_LOW;
							tick_count = 0;
						end
					end
					ws2812_pkg::PH_LOW: begin
						line_q = 1'b0;
						tick_count++;
						if (tick_count >= (bit_is_one ? cfg_one_low : cfg_zero_low)) begin
							tick_count = 0;
							bit_pos++;
							shift_word = shift_word << 1;
							if (bit_pos > ws2812_pkg::LAST_BIT) begin
								pixel_pos++;
								if (pixel_pos >= strip_led_total()) begin
									wave_phase = ws2812_pkg::PH_GAP;
								end else begin
									shift_word = pixel_mem[pixel_pos];
									bit_pos    = 0;
									wave_phase = ws2812_pkg::PH_HIGH;
								end
							end else begin
								wave_phase = ws2812_pkg::PH_HIGH;
							end
						end
					end
					ws2812_pkg::PH_GAP: begin
						line_q = 1'b0;
						tick_count++;
						if (tick_count >= cfg_gap) begin
							tick_count = 0;
							wave_phase = ws2812_pkg::PH_IDLE;
							strip_busy = 1'b0;
							done       = 1'b1;
						end
					end
					default: line_q = 1'b0;
				endcase
			end
			default: ;
		endcase
		res.line_level = line_q;
		res.busy_res   = strip_busy;
		res.frame_done = done;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_request(input logic [1:0] mode, input logic [6:0] idx,
			input logic [7:0] red, green, blue);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {1'b0, blue, green, red, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		strip_expected.push_back(advance_strip(mode, idx, red, green, blue));
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_request(ws2812_pkg::MODE_TICK, 7'($urandom_range(0, 127)), 8'($urandom),
			8'($urandom), 8'($urandom));
	endtask

	task automatic run_to_idle();
		while (strip_busy)
			send_tick();
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (strip_expected.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic apb_access(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
			input logic [31:0] rd_expected);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (wr) begin
			case (idx)
				ws2812_pkg::REG_ZERO_HIGH: cfg_zero_high = wdata[7:0];
				ws2812_pkg::REG_ZERO_LOW:  cfg_zero_low  = wdata[7:0];
				ws2812_pkg::REG_ONE_HIGH:  cfg_one_high  = wdata[7:0];
				ws2812_pkg::REG_ONE_LOW:   cfg_one_low   = wdata[7:0];
				ws2812_pkg::REG_GAP:       cfg_gap       = wdata[15:0];
				ws2812_pkg::REG_LED_COUNT: cfg_led_count = wdata[6:0];
				default: ;
			endcase
		end else if (prdata !== rd_expected) begin
			report_mismatch($sformatf("register %0d reads %0h, want %0h",
				idx, prdata, rd_expected));
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [7:0] zh, zl, oh, ol, input logic [15:0] gap,
			input logic [6:0] leds);
		apb_access(ws2812_pkg::REG_ZERO_HIGH, 1'b1, {24'd0, zh}, '0);
		apb_access(ws2812_pkg::REG_ZERO_LOW, 1'b1, {24'd0, zl}, '0);
		apb_access(ws2812_pkg::REG_ONE_HIGH, 1'b1, {24'd0, oh}, '0);
		apb_access(ws2812_pkg::REG_ONE_LOW, 1'b1, {24'd0, ol}, '0);
		apb_access(ws2812_pkg::REG_GAP, 1'b1, {16'd0, gap}, '0);
		apb_access(ws2812_pkg::REG_LED_COUNT, 1'b1, {25'd0, leds}, '0);
	endtask

	task automatic test_register_reset();
		apb_access(ws2812_pkg::REG_ZERO_HIGH, 1'b0, '0, {24'd0, ws2812_pkg::ZERO_HIGH_RST});
		apb_access(ws2812_pkg::REG_ZERO_LOW, 1'b0, '0, {24'd0, ws2812_pkg::ZERO_LOW_RST});
		apb_access(ws2812_pkg::REG_ONE_HIGH, 1'b0, '0, {24'd0, ws2812_pkg::ONE_HIGH_RST});
		apb_access(ws2812_pkg::REG_ONE_LOW, 1'b0, '0, {24'd0, ws2812_pkg::ONE_LOW_RST});
		apb_access(ws2812_pkg::REG_GAP, 1'b0, '0, {16'd0, ws2812_pkg::GAP_RST});
		apb_access(ws2812_pkg::REG_LED_COUNT, 1'b0, '0, {25'd0, ws2812_pkg::LED_COUNT_RST});
	endtask

	// first bit's high phase at reset timing, then short timing takes over mid-frame
	task automatic test_default_timing();
		apb_access(ws2812_pkg::REG_LED_COUNT, 1'b1, 32'd1, '0);
		send_request(ws2812_pkg::MODE_WRITE, 7'd0, 8'h3C, 8'hA5, 8'h81);
		send_request(ws2812_pkg::MODE_START, 7'd0, 8'h00, 8'h00, 8'h00);
		repeat (46) send_tick();
		drain_results();
		set_timing(8'd1, 8'd1, 8'd1, 8'd1, 16'd1, 7'd1);
		run_to_idle();
		drain_results();
	endtask

	task automatic test_directed_requests();
		set_timing(8'd1, 8'd2, 8'd2, 8'd1, 16'd2, 7'd1);
		send_tick();                                          // idle tick
		send_request(MODE_UNUSED, 7'h7F, 8'hFF, 8'hFF, 8'hFF);
		send_request(ws2812_pkg::MODE_WRITE, 7'd0, 8'hFF, 8'hFF, 8'hFF);
		send_request(ws2812_pkg::MODE_WRITE, 7'd1, 8'h00, 8'h00, 8'h00);
		send_request(ws2812_pkg::MODE_WRITE, 7'd2, 8'h01, 8'h80, 8'h7F);
		send_request(ws2812_pkg::MODE_WRITE, 7'd71, 8'hAA, 8'h55, 8'hC3);
		send_request(ws2812_pkg::MODE_WRITE, 7'd72, 8'h12, 8'h34, 8'h56);  // past the store
		send_request(ws2812_pkg::MODE_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'hFF);
		send_request(ws2812_pkg::MODE_START, 7'd0, 8'h00, 8'h00, 8'h00);
		send_request(ws2812_pkg::MODE_WRITE, 7'd1, 8'hFF, 8'hFF, 8'hFF);   // ignored while busy
		send_tick();
		send_request(ws2812_pkg::MODE_START, 7'd0, 8'h00, 8'h00, 8'h00);
		send_request(MODE_UNUSED, 7'd0, 8'h00, 8'h00, 8'h00);
		run_to_idle();
		drain_results();
	endtask

	task automatic test_timing_extremes();
		// zero timings act as one tick, zero count as one pixel
		set_timing(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 7'd0);
		send_request(ws2812_pkg::MODE_START, 7'd0, 8'h00, 8'h00, 8'h00);
		run_to_idle();
		drain_results();
	endtask

	task automatic test_output_stall();
		set_timing(8'd1, 8'd2, 8'd2, 8'd1, 16'd3, 7'd1);
		send_request(ws2812_pkg::MODE_WRITE, 7'd0, 8'($urandom), 8'($urandom), 8'($urandom));
		send_request(ws2812_pkg::MODE_WRITE, 7'd1, 8'($urandom), 8'($urandom), 8'($urandom));
		send_request(ws2812_pkg::MODE_START, 7'd0, 8'h00, 8'h00, 8'h00);
		hold_cycles = 300;
		repeat (80) send_tick();
		run_to_idle();
		drain_results();
	endtask

	task automatic test_random_traffic();
		int unsigned counted;
		logic [1:0]  mode;
		logic [6:0]  idx;
		set_timing(8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
			8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
			16'($urandom_range(0, 4)), 7'($urandom_range(0, 1)));
		counted = 0;
		while (counted < RANDOM_PHASE_ITEMS) begin
			if (strip_busy) begin
				case ($urandom_range(0, 19))
					0:       mode = ws2812_pkg::MODE_WRITE;
					1:       mode = ws2812_pkg::MODE_START;
					2:       mode = MODE_UNUSED;
					default: mode = ws2812_pkg::MODE_TICK;
				endcase
				if (mode == ws2812_pkg::MODE_TICK)
					counted++;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: mode = ws2812_pkg::MODE_WRITE;
					4, 5, 6:    mode = ws2812_pkg::MODE_START;
					7, 8:       mode = ws2812_pkg::MODE_TICK;
					default:    mode = MODE_UNUSED;
				endcase
				counted++;
			end
			idx = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
				7'($urandom_range(0, 3));
			send_request(mode, idx, 8'($urandom), 8'($urandom), 8'($urandom));
		end
		run_to_idle();
		drain_results();
	endtask

	// output side: random stalls, plus a long hold when a test asks for one
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles - 1) @(negedge clk);
				hold_cycles = 0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		strip_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (strip_expected.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				want = strip_expected.pop_front();
				if (m_tdata[0] !== want.line_level)
					report_mismatch($sformatf("line_level %b, want %b",
						m_tdata[0], want.line_level));
				if (m_tdata[1] !== want.busy_res)
					report_mismatch($sformatf("busy_res %b, want %b",
						m_tdata[1], want.busy_res));
				if (m_tlast !== want.frame_done)
					report_mismatch($sformatf("frame_done %b, want %b",
						m_tlast, want.frame_done));
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ws2812_pkg::MODE_WRITE;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		reset_strip_model();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_register_reset();
		test_default_timing();
		test_directed_requests();
		test_timing_extremes();
		test_output_stall();
		test_random_traffic();
		test_random_traffic();
		idle_on = 1'b0;
		test_random_traffic();

		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
